/* hdl/iadc_pkg.sv */
// Package for the inversion and adjacent-descent counter.
// Holds the transfer payload types, sizing constants and sequencer states.
// No dependencies.
package iadc_pkg;

    localparam int unsigned MAX_LEN    = 1024;
    localparam int unsigned ADDR_W     = $clog2(MAX_LEN);
    localparam int unsigned COUNT_W    = $clog2(MAX_LEN + 1);
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned GLOBAL_W   = 19;
    localparam int unsigned ADJ_W      = 10;
    localparam logic [GLOBAL_W-1:0] GLOBAL_MAX = '1;
    localparam logic [ADJ_W-1:0]    ADJ_MAX    = '1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [GLOBAL_W-1:0] global_count;
        logic [ADJ_W-1:0]    adjacent_count;
        logic                counts_equal;
        logic                overflow;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

/* hdl/inversion_and_adjacent_descent_counter.sv */
// Inversion and adjacent-descent counter, top level.
// Depends on iadc_pkg (payload types, sizes, sequencer states).
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one sequence element per
//   transfer; s_data.last marks the final element. Result channel
//   m_valid/m_ready/m_data carries one result per sequence: the number of
//   strictly inverted pairs, the number of strictly descending neighbors,
//   their equality, and an overflow flag.
//   Each element is compared against every stored earlier element, one per
//   cycle, through the single read port of the element store and one shared
//   magnitude comparator. With n elements already stored (n up to MAX_LEN - 1),
//   s_ready stays low until all n have been compared and the element is
//   written to the store; an element beyond MAX_LEN is dropped and only sets
//   overflow. The last element then passes through ST_DONE, which loads the
//   result register.
//   Reset (aresetn low, synchronous) clears all counts, the fill count and
//   the result valid flag; the store needs no clearing, since only entries
//   written earlier in the same sequence are read.
//   A stalled receiver: the result waits in its output register while the
//   next sequence is taken in; the block only holds off when a second result
//   is ready and the first has not yet been transferred.
module inversion_and_adjacent_descent_counter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  iadc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output iadc_pkg::out_item_t m_data
);
    import iadc_pkg::*;

    // Element store: one write port, one registered read port.
    logic [VALUE_W-1:0] mem [MAX_LEN];
    logic [VALUE_W-1:0] mem_q;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;       // stored elements
    logic [COUNT_W-1:0]  k_reg, k_next;               // scan read index
    logic                pend_reg, pend_next;         // mem_q holds a valid entry
    logic [VALUE_W-1:0]  value_reg, value_next;       // element being absorbed
    logic                last_reg, last_next;
    logic [VALUE_W-1:0]  prev_reg, prev_next;
    logic [GLOBAL_W-1:0] global_reg, global_next;
    logic [ADJ_W-1:0]    adj_reg, adj_next;
    logic                ovf_reg, ovf_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    assign rd_addr = k_reg[ADDR_W-1:0];
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[ADDR_W-1:0]] <= value_reg;
        end
        mem_q <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            k_reg       <= '0;
            pend_reg    <= 1'b0;
            global_reg  <= '0;
            adj_reg     <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            k_reg       <= k_next;
            pend_reg    <= pend_next;
            global_reg  <= global_next;
            adj_reg     <= adj_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        value_reg  <= value_next;
        last_reg   <= last_next;
        prev_reg   <= prev_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        pend_next    = 1'b0;
        value_next   = value_reg;
        last_next    = last_reg;
        prev_next    = prev_reg;
        global_next  = global_reg;
        adj_next     = adj_reg;
        ovf_next     = ovf_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    value_next = s_data.value;
                    last_next  = s_data.last;
                    if (count_reg >= COUNT_W'(MAX_LEN)) begin
                        // store full: element dropped
                        ovf_next   = 1'b1;
                        state_next = s_data.last ? ST_DONE : ST_IDLE;
                    end else begin
                        k_next     = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // compare the entry read last cycle
                if (pend_reg && (mem_q > value_reg) && (global_reg != GLOBAL_MAX)) begin
                    global_next = global_reg + 1'b1;
                end
                if (k_reg != count_reg) begin
                    k_next    = k_reg + 1'b1;
                    pend_next = 1'b1;
                end else if (!pend_reg) begin
                    // scan drained: store element, update descent count
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    prev_next  = value_reg;
                    if ((count_reg != '0) && (prev_reg > value_reg) && (adj_reg != ADJ_MAX)) begin
                        adj_next = adj_reg + 1'b1;
                    end
                    state_next = last_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.global_count   = global_reg;
                    m_data_next.adjacent_count = adj_reg;
                    m_data_next.counts_equal   = (global_reg == GLOBAL_W'(adj_reg));
                    m_data_next.overflow       = ovf_reg;
                    m_valid_next = 1'b1;
                    count_next   = '0;
                    global_next  = '0;
                    adj_next     = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
